@@ rtl/track_aware_box_suppression_top_assert.svh @@
// Assertion macros shared by the suppression block modules
`ifndef TRACK_AWARE_BOX_SUPPRESSION_TOP_ASSERT_SVH
`define TRACK_AWARE_BOX_SUPPRESSION_TOP_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define TABS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TABS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tabs_pkg.sv @@
// Package: command codes, register indexes and request type
`timescale 1ns / 1ps
package tabs_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_TRACK = 2'd1;
    localparam logic [1:0] CMD_DET   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic CFG_MIN_SCORE = 1'b0;
    localparam logic CFG_OVERLAP   = 1'b1;

    localparam logic [15:0] MIN_SCORE_RESET = 16'd32768;
    localparam logic [15:0] OVERLAP_RESET   = 16'd32768;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] left_x;
        logic [15:0] top_y;
        logic [15:0] right_x;
        logic [15:0] bottom_y;
        logic [15:0] conf_score;
        logic        track_alive;
    } t_req;

endpackage

@@ rtl/track_aware_box_suppression_top.sv @@
// Top level: configuration registers, front queue and suppression back end
// A track request is answered from the idle state, a detection under the score floor
// skips the scan, and other detections scan every track, then every kept box.
// One request is carried out at a time; output stalls delay the result.
// Up to 2 requests queue ahead while a result waits in the output register.
// Synchronous active-low reset empties stores and queue, loads both registers with 32768.
`timescale 1ns / 1ps
module track_aware_box_suppression_top #(
    parameter int MAX_TRACKS = 64,
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_left_x,
    input  logic [15:0] i_top_y,
    input  logic [15:0] i_right_x,
    input  logic [15:0] i_bottom_y,
    input  logic [15:0] i_conf_score,
    input  logic        i_track_alive,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_keep,
    output logic        o_store_full,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tabs_pkg::*;

    t_req        req;
    t_req        head;
    logic        head_valid;
    logic        head_pop;
    logic [15:0] r_min_score;
    logic [15:0] r_overlap;

    assign o_cfg_ready = 1'b1;
    assign req = '{cmd: i_command, left_x: i_left_x, top_y: i_top_y,
                   right_x: i_right_x, bottom_y: i_bottom_y,
                   conf_score: i_conf_score, track_alive: i_track_alive};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_score <= MIN_SCORE_RESET;
            r_overlap   <= OVERLAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_SCORE: r_min_score <= i_cfg_data;
                CFG_OVERLAP:   r_overlap   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tabs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req        (req),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (head_pop)
    );

    tabs_back #(
        .MAX_TRACKS (MAX_TRACKS),
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (head_pop),
        .i_min_score  (r_min_score),
        .i_overlap    (r_overlap),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_keep       (o_keep),
        .o_store_full (o_store_full)
    );

endmodule

@@ rtl/tabs_front.sv @@
// Front end: accepts requests, drops CMD_NONE requests, queues the rest
`timescale 1ns / 1ps
`include "track_aware_box_suppression_top_assert.svh"
module tabs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  tabs_pkg::t_req  i_req,
    output tabs_pkg::t_req  o_head,
    output logic            o_head_valid,
    input  logic            i_pop
);
    import tabs_pkg::*;

    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       accept;
    logic       push;
    logic       pop;
    logic [1:0] n_cnt;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign accept       = i_in_valid && !o_in_stall;
    assign push         = accept && (i_req.cmd != CMD_NONE);
    assign pop          = i_pop && (r_cnt != 2'd0);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_req;
        end
    end

    `TABS_ASSERT_ALWAYS(a_q_depth, i_clk, i_rst_n, r_cnt <= 2'd2, "queue overfilled")
    `TABS_ASSERT_NEXT(a_q_stall, i_clk, i_rst_n, r_cnt == 2'd2 && !i_pop, o_in_stall, "no stall when full")

endmodule

@@ rtl/tabs_back.sv @@
// Back end: stores, shared pipelined IoU unit and result register
`timescale 1ns / 1ps
`include "track_aware_box_suppression_top_assert.svh"
module tabs_back #(
    parameter int MAX_TRACKS = 64,
    parameter int MAX_KEPT   = 64,
    parameter int COORD_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tabs_pkg::t_req  i_head,
    input  logic            i_head_valid,
    output logic            o_pop,
    input  logic [15:0]     i_min_score,
    input  logic [15:0]     i_overlap,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_keep,
    output logic            o_store_full
);
    import tabs_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * CB + 2;
    localparam int UW  = 2 * CB + 4;
    localparam int BW  = 4 * CB;
    localparam int TAW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int KAW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int KCW = $clog2(MAX_KEPT + 1);
    localparam int IW  = (TCW > KCW) ? TCW : KCW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    function automatic logic [CB-1:0] coord_of(input logic [15:0] raw);
        logic [31:0] ext;
        ext = {16'd0, raw};
        return ext[CB-1:0];
    endfunction

    logic [BW-1:0]  r_track_mem [MAX_TRACKS];
    logic [BW-1:0]  r_kept_mem  [MAX_KEPT];
    logic [15:0]    r_score_mem [MAX_KEPT];

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    logic [TCW-1:0] r_track_cnt;
    logic [KCW-1:0] r_kept_cnt;
    logic [IW-1:0]  r_idx;
    logic           r_phase;
    logic           r_hit;
    logic [BW-1:0]  r_box;
    logic [15:0]    r_score;
    logic           r_out_vld;
    logic           r_out_keep;
    logic           r_out_full;

    logic           out_free;
    logic           out_load;
    logic           n_keep;
    logic           n_full;
    logic           issue;
    logic           trk_wr;
    logic           kept_wr;
    logic           pipe_busy;

    // read stage
    logic           r_rd_vld;
    logic           r_rd_kept;
    logic [BW-1:0]  r_tb;
    logic [BW-1:0]  r_kb;
    logic [15:0]    r_ks;
    // geometry stage
    logic           r2_vld;
    logic           r2_kept;
    logic           r2_higher;
    logic [DW-1:0]  r2_iw, r2_ih;
    logic signed [DW-1:0] r2_w1, r2_h1, r2_w2, r2_h2;
    // product stage
    logic           r3_vld;
    logic           r3_kept;
    logic           r3_higher;
    logic [PW-1:0]  r3_inter;
    logic signed [PW-1:0] r3_a1, r3_a2;
    // union stage
    logic           r4_vld;
    logic           r4_kept;
    logic           r4_higher;
    logic [PW-1:0]  r4_inter;
    logic signed [UW-1:0] r4_uni;
    // threshold product stage
    logic           r5_vld;
    logic           r5_kept;
    logic           r5_higher;
    logic           r5_pos;
    logic [PW-1:0]  r5_inter;
    logic [31:0]    r5_plo;
    logic [UW-1:0]  r5_phi;

    logic [BW-1:0]  sel_box;
    logic signed [CB-1:0] sl, st, sr, sb, dl, dt, dr, db;
    logic signed [CB-1:0] mxl, mxt, mnr, mnb;
    logic signed [DW-1:0] diw, dih;
    logic [UW+15:0] lhs, rhs;
    logic           ovl;

    assign out_free  = !r_out_vld || !i_out_stall;
    assign pipe_busy = r_rd_vld || r2_vld || r3_vld || r4_vld || r5_vld;
    assign o_pop     = (r_state == ST_IDLE) && i_head_valid && out_free;

    assign o_out_valid  = r_out_vld;
    assign o_keep       = r_out_keep;
    assign o_store_full = r_out_full;

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        n_keep   = 1'b0;
        n_full   = 1'b0;
        issue    = 1'b0;
        trk_wr   = 1'b0;
        kept_wr  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    unique case (i_head.cmd)
                        CMD_TRACK: begin
                            out_load = 1'b1;
                            trk_wr   = i_head.track_alive
                                       && (r_track_cnt < TCW'(MAX_TRACKS));
                            n_full   = i_head.track_alive
                                       && (r_track_cnt >= TCW'(MAX_TRACKS));
                        end
                        CMD_DET: begin
                            n_state = (i_head.conf_score < i_min_score) ? ST_DONE : ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!r_phase) begin
                    issue = (TCW'(r_idx) < r_track_cnt);
                end else begin
                    issue = (KCW'(r_idx) < r_kept_cnt);
                    if (!issue) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_keep   = !r_hit;
                    kept_wr  = !r_hit && (r_kept_cnt < KCW'(MAX_KEPT));
                    n_full   = !r_hit && (r_kept_cnt >= KCW'(MAX_KEPT));
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_track_cnt <= '0;
            r_kept_cnt  <= '0;
            r_idx       <= '0;
            r_phase     <= 1'b0;
            r_hit       <= 1'b0;
            r_out_vld   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            r2_vld   <= r_rd_vld;
            r3_vld   <= r2_vld;
            r4_vld   <= r3_vld;
            r5_vld   <= r4_vld;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (o_pop && i_head.cmd == CMD_CLEAR) begin
                r_track_cnt <= '0;
                r_kept_cnt  <= '0;
            end
            if (trk_wr) begin
                r_track_cnt <= r_track_cnt + TCW'(1);
            end
            if (kept_wr) begin
                r_kept_cnt <= r_kept_cnt + KCW'(1);
            end
            if (o_pop && i_head.cmd == CMD_DET) begin
                r_idx   <= '0;
                r_phase <= 1'b0;
                r_hit   <= (i_head.conf_score < i_min_score);
            end
            if (r_state == ST_SCAN) begin
                if (issue) begin
                    r_idx <= r_idx + IW'(1);
                end else if (!r_phase) begin
                    r_idx   <= '0;
                    r_phase <= 1'b1;
                end
            end
            if (r5_vld && ovl && (!r5_kept || r5_higher)) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_box   <= {coord_of(i_head.left_x), coord_of(i_head.top_y),
                        coord_of(i_head.right_x), coord_of(i_head.bottom_y)};
            r_score <= i_head.conf_score;
        end
        if (out_load) begin
            r_out_keep <= n_keep;
            r_out_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (trk_wr) begin
            r_track_mem[r_track_cnt[TAW-1:0]] <= {coord_of(i_head.left_x),
                coord_of(i_head.top_y), coord_of(i_head.right_x),
                coord_of(i_head.bottom_y)};
        end
        r_tb <= r_track_mem[r_idx[TAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (kept_wr) begin
            r_kept_mem[r_kept_cnt[KAW-1:0]]  <= r_box;
            r_score_mem[r_kept_cnt[KAW-1:0]] <= r_score;
        end
        r_kb <= r_kept_mem[r_idx[KAW-1:0]];
        r_ks <= r_score_mem[r_idx[KAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_rd_kept <= r_phase;
    end

    always_comb begin
        sel_box = r_rd_kept ? r_kb : r_tb;
        sl  = $signed(sel_box[4*CB-1:3*CB]);
        st  = $signed(sel_box[3*CB-1:2*CB]);
        sr  = $signed(sel_box[2*CB-1:CB]);
        sb  = $signed(sel_box[CB-1:0]);
        dl  = $signed(r_box[4*CB-1:3*CB]);
        dt  = $signed(r_box[3*CB-1:2*CB]);
        dr  = $signed(r_box[2*CB-1:CB]);
        db  = $signed(r_box[CB-1:0]);
        mxl = (sl > dl) ? sl : dl;
        mxt = (st > dt) ? st : dt;
        mnr = (sr < dr) ? sr : dr;
        mnb = (sb < db) ? sb : db;
        diw = DW'(mnr) - DW'(mxl);
        dih = DW'(mnb) - DW'(mxt);
    end

    always_ff @(posedge i_clk) begin
        r2_kept   <= r_rd_kept;
        r2_higher <= r_ks > r_score;
        r2_iw     <= diw[DW-1] ? '0 : diw;
        r2_ih     <= dih[DW-1] ? '0 : dih;
        r2_w1     <= DW'(sr) - DW'(sl);
        r2_h1     <= DW'(sb) - DW'(st);
        r2_w2     <= DW'(dr) - DW'(dl);
        r2_h2     <= DW'(db) - DW'(dt);

        r3_kept   <= r2_kept;
        r3_higher <= r2_higher;
        r3_inter  <= PW'(r2_iw) * PW'(r2_ih);
        r3_a1     <= PW'(r2_w1) * PW'(r2_h1);
        r3_a2     <= PW'(r2_w2) * PW'(r2_h2);

        r4_kept   <= r3_kept;
        r4_higher <= r3_higher;
        r4_inter  <= r3_inter;
        r4_uni    <= UW'(r3_a1) + UW'(r3_a2) - $signed(UW'(r3_inter));

        r5_kept   <= r4_kept;
        r5_higher <= r4_higher;
        r5_inter  <= r4_inter;
        r5_pos    <= (r4_uni > 0);
        r5_plo    <= {16'd0, i_overlap} * {16'd0, r4_uni[15:0]};
        r5_phi    <= UW'(i_overlap) * UW'(r4_uni[UW-1:16]);
    end

    always_comb begin
        lhs = (UW + 16)'({r5_inter, 16'd0});
        rhs = (UW + 16)'({r5_phi, 16'd0}) + (UW + 16)'(r5_plo);
        ovl = r5_pos && (lhs > rhs);
    end

    `TABS_ASSERT_ALWAYS(a_trk_cnt, i_clk, i_rst_n,
        r_track_cnt <= TCW'(MAX_TRACKS), "track count over limit")
    `TABS_ASSERT_ALWAYS(a_kept_cnt, i_clk, i_rst_n,
        r_kept_cnt <= KCW'(MAX_KEPT), "kept count over limit")
    `TABS_ASSERT_NEXT(a_kept_inc, i_clk, i_rst_n, kept_wr,
        r_kept_cnt == $past(r_kept_cnt) + KCW'(1), "kept count did not advance")

endmodule
